// File: src/mvp_pkg.sv
// Shared constants and types for the matrix-vector projection block.
package mvp_pkg;

   localparam int HIDDEN_MAX = 64;
   localparam int QUERY_MAX  = 16;

   localparam int HL_W   = 7;
   localparam int QL_W   = 5;
   localparam int COL_W  = $clog2(HIDDEN_MAX);
   localparam int ROW_W  = $clog2(QUERY_MAX);
   localparam int COEF_DEPTH = QUERY_MAX * HIDDEN_MAX;
   localparam int SAMPLE_W = 16;
   localparam int ACC_W  = 40;
   localparam int NUM_W  = 48;

   localparam int PADDR_W = 4;

   // register indexes on the csr port
   localparam logic [1:0] REG_HIDDEN_LENGTH  = 2'd0;
   localparam logic [1:0] REG_QUERY_LENGTH   = 2'd1;
   localparam logic [1:0] REG_NORMALIZE_MODE = 2'd2;

   localparam logic KIND_COEF   = 1'b0;
   localparam logic KIND_HIDDEN = 1'b1;

   typedef enum logic {
      OP_SQRT,
      OP_DIV
   } rd_op_type;

   typedef struct packed {
      logic      start;
      rd_op_type op;
   } rd_ctl_type;

   typedef struct packed {
      logic done;
      logic busy;
   } rd_stat_type;

endpackage

// File: src/mvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/mvp_rootdiv.sv
// Shared bit-serial unit: 64-bit integer square root or 48/32 unsigned divide.
module mvp_rootdiv (
   input  logic                       clock,
   input  logic                       reset,
   input  mvp_pkg::rd_ctl_type        ctl,
   input  logic [63:0]                operand,
   input  logic [31:0]                divisor,
   output mvp_pkg::rd_stat_type       stat,
   output logic [mvp_pkg::NUM_W-1:0]  result
);

   typedef enum logic [1:0] {
      U_IDLE,
      U_SQRT,
      U_DIV
   } ustate_type;

   ustate_type  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] s_ff, s_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        done_ff, done_in;

   logic [63:0] trial;
   logic [32:0] rem_shift;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      s_in     = s_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      done_in  = 1'b0;
      trial     = res_ff + bit_ff;
      rem_shift = {rem_ff, s_ff[mvp_pkg::NUM_W-1]};

      case (state_ff)
         U_IDLE: begin
            if (ctl.start) begin
               s_in   = operand;
               res_in = '0;
               rem_in = '0;
               den_in = divisor;
               bit_in = 64'd1 << 62;
               if (ctl.op == mvp_pkg::OP_SQRT) begin
                  cnt_in   = 6'd31;
                  state_in = U_SQRT;
               end else begin
                  cnt_in   = 6'(mvp_pkg::NUM_W - 1);
                  state_in = U_DIV;
               end
            end
         end
         U_SQRT: begin
            if (s_ff >= trial) begin
               s_in   = s_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         U_DIV: begin
            // restoring divide, one quotient bit per cycle into res
            s_in = s_ff << 1;
            if (rem_shift >= {1'b0, den_ff}) begin
               rem_in = 32'(rem_shift - {1'b0, den_ff});
               res_in = {res_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_shift[31:0];
               res_in = {res_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      s_ff   <= s_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.done = done_ff;
   assign stat.busy = (state_ff != U_IDLE);
   assign result    = res_ff[mvp_pkg::NUM_W-1:0];

endmodule

// File: src/matrix_vector_projection_l2.sv
// Top level: csr, coefficient/hidden/result stores, MAC datapath and sequencer.
//
// Coefficient loads and non-final hidden elements only write their stores. The
// hidden element at column hidden_length-1 starts a vector pass: one shared
// 32x32 multiplier runs each row's dot product at one product per cycle and
// then squares the rounded row sum; with normalization on and a nonzero sum
// of squares, a 32-step square root per pass and a 48-step divide per row
// follow on a shared bit-serial unit; then results come out one per cycle,
// row 0 first, with rsp_strobe high for exactly one cycle each. busy is high
// for the whole pass up to but not including the last result's strobe; start
// is ignored while busy. Results cannot be stalled.
module matrix_vector_projection_l2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [3:0]  req_row_index,
   input  logic [5:0]  req_column_index,
   input  logic signed [15:0] req_sample_value,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_out_row,
   output logic signed [31:0] rsp_projected_value,
   output logic        rsp_last_row,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [mvp_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_MAC, S_DRAIN, S_ROUND, S_SQ, S_SQACC, S_ROOT_GO, S_ROOT_WAIT,
      S_NRD, S_NDIV_GO, S_NDIV_WAIT, S_EMIT
   } state_type;

   // csr
   logic [mvp_pkg::HL_W-1:0] hl_reg_ff;
   logic [mvp_pkg::QL_W-1:0] ql_reg_ff;
   logic                     norm_ff;
   logic [mvp_pkg::HL_W-1:0] hl;
   logic [mvp_pkg::QL_W-1:0] ql;
   logic                     csr_wr;
   logic [1:0]               csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_wr    = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hl_reg_ff <= mvp_pkg::HL_W'(mvp_pkg::HIDDEN_MAX);
         ql_reg_ff <= mvp_pkg::QL_W'(mvp_pkg::QUERY_MAX);
         norm_ff   <= 1'b0;
      end else if (csr_wr) begin
         case (csr_index)
            mvp_pkg::REG_HIDDEN_LENGTH:  hl_reg_ff <= pwdata[mvp_pkg::HL_W-1:0];
            mvp_pkg::REG_QUERY_LENGTH:   ql_reg_ff <= pwdata[mvp_pkg::QL_W-1:0];
            mvp_pkg::REG_NORMALIZE_MODE: norm_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         mvp_pkg::REG_HIDDEN_LENGTH:  prdata = 32'(hl_reg_ff);
         mvp_pkg::REG_QUERY_LENGTH:   prdata = 32'(ql_reg_ff);
         mvp_pkg::REG_NORMALIZE_MODE: prdata = 32'(norm_ff);
         default:                     prdata = '0;
      endcase
   end

   always_comb begin
      if (hl_reg_ff == '0) hl = mvp_pkg::HL_W'(1);
      else if (hl_reg_ff > mvp_pkg::HL_W'(mvp_pkg::HIDDEN_MAX))
         hl = mvp_pkg::HL_W'(mvp_pkg::HIDDEN_MAX);
      else hl = hl_reg_ff;
      if (ql_reg_ff == '0) ql = mvp_pkg::QL_W'(1);
      else if (ql_reg_ff > mvp_pkg::QL_W'(mvp_pkg::QUERY_MAX))
         ql = mvp_pkg::QL_W'(mvp_pkg::QUERY_MAX);
      else ql = ql_reg_ff;
   end

   // sequencer state
   state_type                  state_ff, state_in;
   logic [mvp_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [mvp_pkg::COL_W-1:0]  col_ff, col_in;
   logic                       v1_ff, v1_in, v2_ff, v2_in;
   logic signed [mvp_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [31:0]         q_ff, q_in;
   logic [63:0]                sumsq_ff, sumsq_in;
   logic [31:0]                n_ff, n_in;
   logic                       neg_ff, neg_in;
   logic                       emit_v_ff, emit_v_in;
   logic [mvp_pkg::ROW_W-1:0]  emit_row_ff, emit_row_in;
   logic                       emit_last_ff, emit_last_in;
   logic signed [63:0]         prod_ff;

   logic accept;
   assign accept = start & ~busy;
   assign busy   = (state_ff != S_IDLE);

   // stores
   logic [15:0] coef_rdata, hid_rdata;
   logic [31:0] row_rdata;
   logic        row_wr;
   logic [31:0] row_wdata;

   mvp_ram #(.WIDTH(mvp_pkg::SAMPLE_W), .DEPTH(mvp_pkg::COEF_DEPTH)) u_coef (
      .clock   (clock),
      .wr_en   (accept && req_kind == mvp_pkg::KIND_COEF),
      .wr_addr ({req_row_index, req_column_index}),
      .wr_data (req_sample_value),
      .rd_addr ({row_ff, col_ff}),
      .rd_data (coef_rdata)
   );

   mvp_ram #(.WIDTH(mvp_pkg::SAMPLE_W), .DEPTH(mvp_pkg::HIDDEN_MAX)) u_hidden (
      .clock   (clock),
      .wr_en   (accept && req_kind == mvp_pkg::KIND_HIDDEN),
      .wr_addr (req_column_index),
      .wr_data (req_sample_value),
      .rd_addr (col_ff),
      .rd_data (hid_rdata)
   );

   mvp_ram #(.WIDTH(32), .DEPTH(mvp_pkg::QUERY_MAX)) u_rows (
      .clock   (clock),
      .wr_en   (row_wr),
      .wr_addr (row_ff),
      .wr_data (row_wdata),
      .rd_addr (row_ff),
      .rd_data (row_rdata)
   );

   // shared multiplier, registered
   logic signed [31:0] mul_a, mul_b;
   always_comb begin
      if (state_ff == S_SQ) begin
         mul_a = q_ff;
         mul_b = q_ff;
      end else begin
         mul_a = 32'(signed'(coef_rdata));
         mul_b = 32'(signed'(hid_rdata));
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // round the Q.26 sum to Q16.16, ties away from zero; the sum of 64
   // products stays well inside 32 bits after the shift
   logic [mvp_pkg::ACC_W-1:0] acc_mag;
   logic [mvp_pkg::ACC_W-1:0] acc_rnd;
   logic signed [31:0]        q_round;
   always_comb begin
      acc_mag = acc_ff[mvp_pkg::ACC_W-1] ? mvp_pkg::ACC_W'(-acc_ff)
                                         : mvp_pkg::ACC_W'(acc_ff);
      acc_rnd = (acc_mag + mvp_pkg::ACC_W'(512)) >> 10;
      q_round = acc_ff[mvp_pkg::ACC_W-1] ? -signed'(acc_rnd[31:0]) : signed'(acc_rnd[31:0]);
   end

   // normalization square root and divide
   mvp_pkg::rd_ctl_type        rd_ctl;
   mvp_pkg::rd_stat_type       rd_stat;
   logic [mvp_pkg::NUM_W-1:0]  rd_result;
   logic [31:0]                row_mag;
   logic [63:0]                rd_operand;
   logic [31:0]                div_sat;

   assign row_mag = row_rdata[31] ? 32'(-row_rdata) : row_rdata;

   always_comb begin
      rd_ctl.start = (state_ff == S_ROOT_GO) || (state_ff == S_NDIV_GO);
      rd_ctl.op    = (state_ff == S_ROOT_GO) ? mvp_pkg::OP_SQRT : mvp_pkg::OP_DIV;
      if (state_ff == S_ROOT_GO) rd_operand = sumsq_ff;
      else rd_operand = 64'({row_mag, 16'b0} + 48'(n_ff >> 1));
   end

   always_comb begin
      if (neg_ff) begin
         if (rd_result > 48'h0000_8000_0000) div_sat = 32'h8000_0000;
         else div_sat = 32'(-rd_result[31:0]);
      end else begin
         if (rd_result > 48'h0000_7FFF_FFFF) div_sat = 32'h7FFF_FFFF;
         else div_sat = rd_result[31:0];
      end
   end

   mvp_rootdiv u_rootdiv (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rd_ctl),
      .operand (rd_operand),
      .divisor (n_ff),
      .stat    (rd_stat),
      .result  (rd_result)
   );

   assign row_wr    = (state_ff == S_ROUND) || (state_ff == S_NDIV_WAIT && rd_stat.done);
   assign row_wdata = (state_ff == S_ROUND) ? q_round : div_sat;

   logic last_row;
   assign last_row = (row_ff == mvp_pkg::ROW_W'(ql - 1'b1));

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      v1_in        = (state_ff == S_MAC);
      v2_in        = v1_ff;
      acc_in       = acc_ff;
      q_in         = q_ff;
      sumsq_in     = sumsq_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      emit_v_in    = 1'b0;
      emit_row_in  = emit_row_ff;
      emit_last_in = 1'b0;

      if (v2_ff) acc_in = acc_ff + prod_ff[mvp_pkg::ACC_W-1:0];

      case (state_ff)
         S_IDLE: begin
            // last hidden element launches the vector pass
            if (accept && req_kind == mvp_pkg::KIND_HIDDEN &&
                req_column_index == mvp_pkg::COL_W'(hl - 1'b1)) begin
               row_in   = '0;
               col_in   = '0;
               acc_in   = '0;
               sumsq_in = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            if (col_ff == mvp_pkg::COL_W'(hl - 1'b1)) state_in = S_DRAIN;
            else col_in = col_ff + 1'b1;
         end
         S_DRAIN: begin
            if (!v1_ff && !v2_ff) state_in = S_ROUND;
         end
         S_ROUND: begin
            q_in     = q_round;
            state_in = S_SQ;
         end
         S_SQ: state_in = S_SQACC;
         S_SQACC: begin
            sumsq_in = sumsq_ff + prod_ff;
            col_in   = '0;
            acc_in   = '0;
            if (last_row) begin
               row_in = '0;
               if (norm_ff && sumsq_in != '0) state_in = S_ROOT_GO;
               else state_in = S_EMIT;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = S_MAC;
            end
         end
         S_ROOT_GO: state_in = S_ROOT_WAIT;
         S_ROOT_WAIT: begin
            if (rd_stat.done) begin
               n_in     = rd_result[31:0];
               state_in = S_NRD;
            end
         end
         S_NRD: state_in = S_NDIV_GO;
         S_NDIV_GO: begin
            neg_in   = row_rdata[31];
            state_in = S_NDIV_WAIT;
         end
         S_NDIV_WAIT: begin
            if (rd_stat.done) begin
               if (last_row) begin
                  row_in   = '0;
                  state_in = S_EMIT;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = S_NRD;
               end
            end
         end
         S_EMIT: begin
            emit_v_in    = 1'b1;
            emit_row_in  = row_ff;
            emit_last_in = last_row;
            if (last_row) state_in = S_IDLE;
            else row_in = row_ff + 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         emit_v_ff    <= 1'b0;
         emit_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         emit_v_ff    <= emit_v_in;
         emit_last_ff <= emit_last_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      acc_ff      <= acc_in;
      q_ff        <= q_in;
      sumsq_ff    <= sumsq_in;
      n_ff        <= n_in;
      neg_ff      <= neg_in;
      emit_row_ff <= emit_row_in;
   end

   assign rsp_strobe          = emit_v_ff;
   assign rsp_out_row         = emit_row_ff;
   assign rsp_projected_value = row_rdata;
   assign rsp_last_row        = emit_last_ff;

endmodule

// File: src/mvp_checker.sv
// Port-level checker for the projection block, bound to the top level.
module mvp_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_kind,
   input logic        rsp_strobe,
   input logic [3:0]  rsp_out_row,
   input logic        rsp_last_row
);

   // a coefficient load never starts a pass
   a_coef_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == mvp_pkg::KIND_COEF) |=> !busy)
      else $error("coefficient load raised busy");

   // results only come out of a pass
   a_rsp_in_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result outside a pass");

   // rows come out back to back in order
   a_row_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_row) |=>
         (rsp_strobe && rsp_out_row == 4'($past(rsp_out_row) + 4'd1)))
      else $error("row sequence broken");

   a_first_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_strobe) |-> (rsp_out_row == '0))
      else $error("first row is not row 0");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_row) |=> !rsp_strobe)
      else $error("transaction after last row");

endmodule

bind matrix_vector_projection_l2 mvp_checker u_mvp_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_kind     (req_kind),
   .rsp_strobe   (rsp_strobe),
   .rsp_out_row  (rsp_out_row),
   .rsp_last_row (rsp_last_row)
);
